### sv/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg: shared types and constants for magnitude level statistics
// Field widths, register map, reset values and controller states.
// ----------------------------------------------------------------------------
package mls_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // result field widths
  localparam int POW_W = 32;
  localparam int MAG_W = 16;
  localparam int TOT_W = 48;
  localparam int CNT_W32 = 32;

  // averaging
  localparam int AVG_W = 21;
  localparam int THR_W = 16;
  localparam int SUM_W = 36;
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_HI_W = SUM_W - DIV_STEPS;

  localparam logic [AVG_W-1:0] AVG_CAP = AVG_W'(1 << 20);
  localparam logic [AVG_W-1:0] AVERAGE_COUNT_RST = AVG_W'(1000);
  localparam logic [THR_W-1:0] PULSE_THRESHOLD_RST = '0;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W = 1;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_AVERAGE_COUNT = 1'b0;
  localparam reg_idx_t REG_PULSE_THRESHOLD = 1'b1;

  // result stream
  localparam int OUT_DATA_W = 224;
  localparam int OUT_USER_W = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

### sv/magnitude_level_statistics.sv
// ----------------------------------------------------------------------------
// magnitude_level_statistics: power, magnitude and level statistics
// Bit-serial squarer, bit-serial square root and two bit-serial dividers
// feeding running peak, total, min/max and block/pulse averages.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample is squared by the shift-add squarer, one
//   bit per cycle, then rooted, one bit per cycle; a sample that closes a
//   block or pulse average then runs the dividers, one quotient bit per
//   cycle. The next sample is accepted only after its result word is loaded
//   into the output register, which waits while out_tvalid is not accepted.
// Reset: synchronous, clears all statistics, min to 65535, count to 1000.
module magnitude_level_statistics #(
  parameter int SAMPLE_BITS = mls_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample_i [SAMPLE_BITS-1:0], sample_q [2*SAMPLE_BITS-1:SAMPLE_BITS]
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // power, magnitude, power_peak, power_total, sample_total, magnitude_max,
  // magnitude_min, block_average, pulse_average
  output logic [mls_pkg::OUT_DATA_W-1:0]       out_tdata,
  // block_done, pulse_done
  output logic [mls_pkg::OUT_USER_W-1:0]       out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mls_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [mls_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [mls_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int PROD_W = 2 * SB;
  localparam int PX_W = (PROD_W > mls_pkg::POW_W) ? PROD_W : mls_pkg::POW_W + 1;
  localparam int RX_W = (SB > mls_pkg::MAG_W) ? SB : mls_pkg::MAG_W + 1;
  localparam int REM_W = SB + 2;
  localparam int STEP_MAX = (SB > mls_pkg::DIV_STEPS) ? SB : mls_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(STEP_MAX + 1);
  localparam int AW = mls_pkg::AVG_W;
  localparam int QW = mls_pkg::DIV_STEPS;
  localparam int HW = mls_pkg::DIV_HI_W;

  // ---------------------------------------------------------------- control
  mls_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             last_step;
  logic             in_acc;
  logic             out_load;

  // ---------------------------------------------------------------- config
  logic [AW-1:0]             average_count_r;
  logic [mls_pkg::THR_W-1:0] pulse_threshold_r;
  logic                      cfg_wr;
  mls_pkg::reg_idx_t         cfg_idx;

  // ---------------------------------------------------------------- squarer
  logic [SB-1:0]     smp_i, smp_q, abs_i, abs_q;
  logic [PROD_W-1:0] mcand_i_r, mcand_q_r, acc_r, acc_nxt;
  logic [SB-1:0]     mplr_i_r, mplr_q_r;

  // ---------------------------------------------------------------- root
  logic [PROD_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [SB-1:0]     root_r, root_nxt;
  logic [REM_W+1:0]  sq_t, sq_trial;
  logic              sq_ge;

  // ---------------------------------------------------------------- update
  logic [PX_W-1:0]            pext;
  logic [RX_W-1:0]            rext;
  logic [mls_pkg::POW_W-1:0]  pow_sat;
  logic [mls_pkg::MAG_W-1:0]  mag_sat;
  logic [AW-1:0]              n_eff;
  logic [mls_pkg::TOT_W:0]    tot_sum;
  logic [mls_pkg::SUM_W-1:0]  bsum_inc, psum_inc;
  logic [AW-1:0]              bc_inc, pc_inc;
  logic                       pulse_hit, bdone_nxt, pdone_nxt;

  logic [mls_pkg::SUM_W-1:0]   block_sum_r, pulse_sum_r;
  logic [AW-1:0]               block_count_r, pulse_count_r;
  logic [mls_pkg::MAG_W-1:0]   block_avg_r, pulse_avg_r, mag_max_r, mag_min_r;
  logic [mls_pkg::POW_W-1:0]   power_peak_r;
  logic [mls_pkg::TOT_W-1:0]   power_total_r;
  logic [mls_pkg::CNT_W32-1:0] sample_total_r;
  logic [mls_pkg::POW_W-1:0]   power_r;
  logic [mls_pkg::MAG_W-1:0]   mag_r;
  logic                        bdone_r, pdone_r;

  // ---------------------------------------------------------------- dividers
  logic [QW-1:0]  bdvd_r, pdvd_r, bquo_r, pquo_r, bquo_nxt, pquo_nxt;
  logic [AW-1:0]  brem_r, prem_r, bdiv_r, pdiv_r;
  logic [AW:0]    bt, pt;
  logic           bge, pge;

  // ---------------------------------------------------------------- output
  logic [mls_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [mls_pkg::OUT_USER_W-1:0] out_tuser_r;
  logic                           out_tvalid_r;

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_tvalid_r;

  // ================================================================ config
  assign cfg_wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx = cfg_paddr[mls_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      average_count_r   <= mls_pkg::AVERAGE_COUNT_RST;
      pulse_threshold_r <= mls_pkg::PULSE_THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mls_pkg::REG_AVERAGE_COUNT:   average_count_r <= cfg_pwdata[AW-1:0];
        mls_pkg::REG_PULSE_THRESHOLD: pulse_threshold_r <= cfg_pwdata[mls_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mls_pkg::REG_AVERAGE_COUNT:   cfg_prdata = mls_pkg::CFG_DATA_W'(average_count_r);
      mls_pkg::REG_PULSE_THRESHOLD: cfg_prdata = mls_pkg::CFG_DATA_W'(pulse_threshold_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // ================================================================ FSM
  assign last_step = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mls_pkg::ST_IDLE: if (in_tvalid) state_nxt = mls_pkg::ST_MUL;
      mls_pkg::ST_MUL:  if (last_step) state_nxt = mls_pkg::ST_SQRT;
      mls_pkg::ST_SQRT: if (last_step) state_nxt = mls_pkg::ST_UPD;
      mls_pkg::ST_UPD: begin
        state_nxt = (bdone_nxt | pdone_nxt) ? mls_pkg::ST_DIV : mls_pkg::ST_OUT;
      end
      mls_pkg::ST_DIV:  if (last_step) state_nxt = mls_pkg::ST_OUT;
      mls_pkg::ST_OUT:  if (!out_tvalid_r || out_tready) state_nxt = mls_pkg::ST_IDLE;
      default:          state_nxt = mls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == mls_pkg::ST_IDLE);
    cfg_pready = 1'b1;
    out_load   = (state_r == mls_pkg::ST_OUT) && (!out_tvalid_r || out_tready);
  end

  assign in_acc = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mls_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        mls_pkg::ST_IDLE: if (in_acc) cnt_r <= CNT_W'(SB - 1);
        mls_pkg::ST_MUL:  cnt_r <= last_step ? CNT_W'(SB - 1) : cnt_r - 1'b1;
        mls_pkg::ST_SQRT: cnt_r <= cnt_r - 1'b1;
        mls_pkg::ST_UPD:  cnt_r <= CNT_W'(QW - 1);
        mls_pkg::ST_DIV:  cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  // ================================================================ squarer
  assign smp_i = in_tdata[SB-1:0];
  assign smp_q = in_tdata[2*SB-1:SB];
  assign abs_i = smp_i[SB-1] ? (~smp_i + 1'b1) : smp_i;
  assign abs_q = smp_q[SB-1] ? (~smp_q + 1'b1) : smp_q;

  // i*i + q*q, one multiplier bit of each square per cycle
  assign acc_nxt = acc_r + (mplr_i_r[0] ? mcand_i_r : '0)
                         + (mplr_q_r[0] ? mcand_q_r : '0);

  always_ff @(posedge clk) begin
    if (state_r == mls_pkg::ST_IDLE) begin
      mcand_i_r <= PROD_W'(abs_i);
      mcand_q_r <= PROD_W'(abs_q);
      mplr_i_r  <= abs_i;
      mplr_q_r  <= abs_q;
      acc_r     <= '0;
    end else if (state_r == mls_pkg::ST_MUL) begin
      mcand_i_r <= mcand_i_r << 1;
      mcand_q_r <= mcand_q_r << 1;
      mplr_i_r  <= mplr_i_r >> 1;
      mplr_q_r  <= mplr_q_r >> 1;
      acc_r     <= acc_nxt;
    end
  end

  // ================================================================ root
  // restoring root: two radicand bits in, one root bit out per cycle
  assign sq_t     = {rem_r, rad_r[PROD_W-1 -: 2]};
  assign sq_trial = (REM_W+2)'({root_r, 2'b01});
  assign sq_ge    = (sq_t >= sq_trial);
  assign rem_nxt  = sq_ge ? REM_W'(sq_t - sq_trial) : REM_W'(sq_t);
  assign root_nxt = {root_r[SB-2:0], sq_ge};

  always_ff @(posedge clk) begin
    if (state_r == mls_pkg::ST_MUL) begin
      rad_r  <= acc_nxt;
      rem_r  <= '0;
      root_r <= '0;
    end else if (state_r == mls_pkg::ST_SQRT) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  // ================================================================ update
  assign pext    = PX_W'(acc_r);
  assign rext    = RX_W'(root_r);
  assign pow_sat = (|pext[PX_W-1:mls_pkg::POW_W]) ? '1 : pext[mls_pkg::POW_W-1:0];
  assign mag_sat = (|rext[RX_W-1:mls_pkg::MAG_W]) ? '1 : rext[mls_pkg::MAG_W-1:0];

  always_comb begin
    if (average_count_r == '0)
      n_eff = AW'(1);
    else if (average_count_r > mls_pkg::AVG_CAP)
      n_eff = mls_pkg::AVG_CAP;
    else
      n_eff = average_count_r;
  end

  assign tot_sum   = {1'b0, power_total_r} + (mls_pkg::TOT_W+1)'(pow_sat);
  assign bsum_inc  = block_sum_r + mls_pkg::SUM_W'(mag_sat);
  assign psum_inc  = pulse_sum_r + mls_pkg::SUM_W'(mag_sat);
  assign bc_inc    = block_count_r + 1'b1;
  assign pc_inc    = pulse_count_r + 1'b1;
  assign pulse_hit = (mag_sat > pulse_threshold_r);
  assign bdone_nxt = (bc_inc >= n_eff);
  assign pdone_nxt = pulse_hit && (pc_inc >= n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_sum_r    <= '0;
      block_count_r  <= '0;
      pulse_sum_r    <= '0;
      pulse_count_r  <= '0;
      block_avg_r    <= '0;
      pulse_avg_r    <= '0;
      mag_max_r      <= '0;
      mag_min_r      <= '1;
      power_peak_r   <= '0;
      power_total_r  <= '0;
      sample_total_r <= '0;
    end else if (state_r == mls_pkg::ST_UPD) begin
      if (pow_sat > power_peak_r) power_peak_r <= pow_sat;
      power_total_r <= tot_sum[mls_pkg::TOT_W] ? '1 : tot_sum[mls_pkg::TOT_W-1:0];
      if (sample_total_r != '1) sample_total_r <= sample_total_r + 1'b1;
      if (mag_sat > mag_max_r) mag_max_r <= mag_sat;
      if (mag_sat < mag_min_r) mag_min_r <= mag_sat;
      if (bdone_nxt) begin
        block_sum_r   <= '0;
        block_count_r <= '0;
      end else begin
        block_sum_r   <= bsum_inc;
        block_count_r <= bc_inc;
      end
      if (pulse_hit) begin
        if (pdone_nxt) begin
          pulse_sum_r   <= '0;
          pulse_count_r <= '0;
        end else begin
          pulse_sum_r   <= psum_inc;
          pulse_count_r <= pc_inc;
        end
      end
    end else if ((state_r == mls_pkg::ST_DIV) && last_step) begin
      if (bdone_r) block_avg_r <= bquo_nxt;
      if (pdone_r) pulse_avg_r <= pquo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mls_pkg::ST_UPD) begin
      power_r <= pow_sat;
      mag_r   <= mag_sat;
      bdone_r <= bdone_nxt;
      pdone_r <= pdone_nxt;
    end
  end

  // ================================================================ dividers
  // sum < count * 2^16, so the quotient fits 16 bits and the upper sum bits
  // seed the remainder
  assign bt       = {brem_r, bdvd_r[QW-1]};
  assign pt       = {prem_r, pdvd_r[QW-1]};
  assign bge      = (bt >= {1'b0, bdiv_r});
  assign pge      = (pt >= {1'b0, pdiv_r});
  assign bquo_nxt = {bquo_r[QW-2:0], bge};
  assign pquo_nxt = {pquo_r[QW-2:0], pge};

  always_ff @(posedge clk) begin
    if (state_r == mls_pkg::ST_UPD) begin
      bdvd_r <= bsum_inc[QW-1:0];
      brem_r <= AW'(bsum_inc[mls_pkg::SUM_W-1 -: HW]);
      bdiv_r <= bc_inc;
      bquo_r <= '0;
      pdvd_r <= psum_inc[QW-1:0];
      prem_r <= AW'(psum_inc[mls_pkg::SUM_W-1 -: HW]);
      pdiv_r <= pc_inc;
      pquo_r <= '0;
    end else if (state_r == mls_pkg::ST_DIV) begin
      bdvd_r <= bdvd_r << 1;
      brem_r <= bge ? AW'(bt - {1'b0, bdiv_r}) : AW'(bt);
      bquo_r <= bquo_nxt;
      pdvd_r <= pdvd_r << 1;
      prem_r <= pge ? AW'(pt - {1'b0, pdiv_r}) : AW'(pt);
      pquo_r <= pquo_nxt;
    end
  end

  // ================================================================ output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {pulse_avg_r, block_avg_r, mag_min_r, mag_max_r, sample_total_r,
                      power_total_r, power_peak_r, mag_r, power_r};
      out_tuser_r <= {pdone_r, bdone_r};
    end
  end

  // ================================================================ checks
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_total_r != '0) |-> (mag_min_r <= mag_max_r))
    else $error("magnitude min above max");

  a_bcount: assert property (@(posedge clk) disable iff (!rst_n)
    (block_count_r < mls_pkg::AVG_CAP) && (pulse_count_r < mls_pkg::AVG_CAP))
    else $error("averaging count past cap");

  a_outsrc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == mls_pkg::ST_OUT))
    else $error("word issued outside output state");

  a_divsrc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mls_pkg::ST_DIV) && $past(state_r != mls_pkg::ST_DIV)
      |-> $past(state_r == mls_pkg::ST_UPD) && $past(bdone_nxt || pdone_nxt))
    else $error("divide started without a closed block");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == mls_pkg::ST_MUL) && !in_tready)
    else $error("accept did not start squarer");

endmodule
